### design/dlm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the dense layer MAC core.
// No dependencies; every other design file refers to it by scoped names.
package dlm_pkg;

  localparam int MAX_INPUTS  = 1024;
  localparam int MAX_OUTPUTS = 64;
  localparam int DATA_WIDTH  = 16;

  localparam int MODE_W     = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 10;
  localparam int BIAS_W     = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = ACC_W + 1;
  localparam int WADDR_W    = ROW_W + COL_W;
  localparam int CNT_W      = 7;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Input item modes.
  localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SHIFT   = 2'd3;

  // Register reset values.
  localparam logic [CNT_W-1:0]   RST_OUT_COUNT   = 7'd1;
  localparam logic               RST_BIAS_ENABLE = 1'b1;
  localparam logic               RST_RELU_ENABLE = 1'b0;
  localparam logic [SHIFT_W-1:0] RST_OUT_SHIFT   = 5'd8;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    logic [DATA_WIDTH-1:0] sample;
    logic [BIAS_W-1:0]     bias_word;
    logic                  last_element;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic [CNT_W-1:0]   out_count;
    logic               bias_enable;
    logic               relu_enable;
    logic [SHIFT_W-1:0] out_shift;
  } cfg_t;

endpackage

### design/dlm_in_if.sv
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with the load/activation payload.
// Depends on dlm_pkg for field widths.
interface dlm_in_if;
  logic                           valid;
  logic                           ready;
  logic [dlm_pkg::MODE_W-1:0]     mode;
  logic [dlm_pkg::ROW_W-1:0]      row;
  logic [dlm_pkg::COL_W-1:0]      column;
  logic [dlm_pkg::DATA_WIDTH-1:0] sample;
  logic [dlm_pkg::BIAS_W-1:0]     bias_word;
  logic                           last_element;

  modport source (output valid, mode, row, column, sample, bias_word, last_element,
                  input ready);
  modport sink (input valid, mode, row, column, sample, bias_word, last_element,
                output ready);
endinterface

### design/dlm_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with one neuron output per word.
// Depends on dlm_pkg for field widths.
interface dlm_out_if;
  logic                           valid;
  logic                           ready;
  logic [dlm_pkg::ROW_W-1:0]      out_index;
  logic [dlm_pkg::DATA_WIDTH-1:0] out_value;
  logic                           out_last;

  modport source (output valid, out_index, out_value, out_last, input ready);
  modport sink (input valid, out_index, out_value, out_last, output ready);
endinterface

### design/dlm_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on dlm_pkg for field widths.
interface dlm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dlm_pkg::CFG_IDX_W-1:0]  index;
  logic [dlm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/dlm_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, drops unused modes and queues the rest.
// Depends on dlm_pkg and dlm_in_if.
module dlm_front (
  input  logic                 clk,
  input  logic                 rst,
  dlm_in_if.sink               item,
  output dlm_pkg::queue_head_t head,
  input  logic                 pop
);

  dlm_pkg::cmd_t                 q_mem [dlm_pkg::QUEUE_DEPTH];
  logic [dlm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dlm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dlm_pkg::QPTR_W:0]      count;
  logic                          accept;
  logic                          push;
  logic                          do_pop;
  dlm_pkg::cmd_t                 cmd_in;

  assign item.ready = (count != (dlm_pkg::QPTR_W + 1)'(dlm_pkg::QUEUE_DEPTH));
  assign accept     = item.valid && item.ready;
  // A word in the unused mode is taken and retired here; it never reaches the back end.
  assign push       = accept && (item.mode != dlm_pkg::MODE_NONE);
  assign do_pop     = pop && (count != '0);

  always_comb begin
    cmd_in.mode         = item.mode;
    cmd_in.row          = item.row;
    cmd_in.column       = item.column;
    cmd_in.sample       = item.sample;
    cmd_in.bias_word    = item.bias_word;
    cmd_in.last_element = item.last_element;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = q_mem[rd_ptr];

endmodule

### design/dlm_back.sv
`timescale 1ns / 1ps
// Back end: executes queued loads and activations, owns the weight, bias and
// accumulator stores, the shared multiplier and the result register. Depends on dlm_pkg.
module dlm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  dlm_pkg::queue_head_t head,
  output logic                 pop,
  input  dlm_pkg::cfg_t        cfg,
  dlm_out_if.source            result
);

  localparam int DW = dlm_pkg::DATA_WIDTH;
  localparam int AW = dlm_pkg::ACC_W;
  localparam int PW = dlm_pkg::PROD_W;
  localparam int SW = dlm_pkg::SUM_W;
  localparam int BW = dlm_pkg::BIAS_W;
  localparam int RW = dlm_pkg::ROW_W;
  localparam int CW = dlm_pkg::CNT_W;

  localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (DW - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MAC      = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_OUT_RD   = 3'd3;
  localparam logic [2:0] ST_OUT_SUM  = 3'd4;
  localparam logic [2:0] ST_OUT_EMIT = 3'd5;

  logic [DW-1:0] weight_mem [2 ** dlm_pkg::WADDR_W];
  logic [BW-1:0] bias_mem   [dlm_pkg::MAX_OUTPUTS];
  logic [AW-1:0] acc_mem    [dlm_pkg::MAX_OUTPUTS];
  logic [dlm_pkg::MAX_OUTPUTS-1:0] acc_valid;

  logic [2:0]                 state;
  logic [RW-1:0]              j;
  logic [dlm_pkg::COL_W-1:0]  act_col;
  logic signed [DW-1:0]       act_x;
  logic                       act_last;

  logic signed [DW-1:0]       w_rd;
  logic [AW-1:0]              acc_rd;
  logic                       acc_rd_v;
  logic [BW-1:0]              bias_rd;

  logic                       s1_v;
  logic [RW-1:0]              s1_j;
  logic                       s2_v;
  logic [RW-1:0]              s2_j;
  logic signed [PW-1:0]       prod;
  logic [AW-1:0]              acc_q;

  logic signed [SW-1:0]       sum;
  logic signed [SW-1:0]       shifted;
  logic [DW-1:0]              sat_value;
  logic [DW-1:0]              final_value;

  logic [CW-1:0]              n_eff;
  logic [RW-1:0]              last_idx;
  logic                       emit;
  logic                       clear_acc;

  logic                       o_valid;
  logic [RW-1:0]              o_index;
  logic [DW-1:0]              o_value;
  logic                       o_last;

  // Zero outputs behaves as one, anything past the store depth as the full depth.
  always_comb begin
    if (cfg.out_count == '0) begin
      n_eff = CW'(1);
    end else if (cfg.out_count > CW'(dlm_pkg::MAX_OUTPUTS)) begin
      n_eff = CW'(dlm_pkg::MAX_OUTPUTS);
    end else begin
      n_eff = cfg.out_count;
    end
  end
  assign last_idx = RW'(n_eff - CW'(1));

  assign pop       = (state == ST_IDLE) && head.valid;
  assign emit      = (state == ST_OUT_EMIT) && (!o_valid || result.ready);
  assign clear_acc = emit && (j == last_idx);

  // Stores: loads write straight from the queue head, reads are registered every cycle.
  always_ff @(posedge clk) begin
    if (pop && (head.cmd.mode == dlm_pkg::MODE_WEIGHT)) begin
      weight_mem[{head.cmd.row, head.cmd.column}] <= head.cmd.sample;
    end
    if (pop && (head.cmd.mode == dlm_pkg::MODE_BIAS)) begin
      bias_mem[head.cmd.row] <= head.cmd.bias_word;
    end
    if (s2_v) begin
      acc_mem[s2_j] <= acc_q + {{(AW - PW){prod[PW-1]}}, prod};
    end
    w_rd    <= weight_mem[{j, act_col}];
    acc_rd  <= acc_mem[j];
    bias_rd <= bias_mem[j];
  end

  // An accumulator that is not marked valid reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
      acc_rd_v  <= 1'b0;
    end else begin
      acc_rd_v <= acc_valid[j];
      if (clear_acc) begin
        acc_valid <= '0;
      end else if (s2_v) begin
        acc_valid[s2_j] <= 1'b1;
      end
    end
  end

  // Multiply-accumulate pipeline: read, multiply, write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= (state == ST_MAC);
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_j  <= j;
    s2_j  <= s1_j;
    prod  <= act_x * w_rd;
    acc_q <= acc_rd_v ? acc_rd : '0;
  end

  always_comb begin
    shifted = sum >>> cfg.out_shift;
    if (shifted > SAT_HI) begin
      sat_value = SAT_HI[DW-1:0];
    end else if (shifted < SAT_LO) begin
      sat_value = SAT_LO[DW-1:0];
    end else begin
      sat_value = shifted[DW-1:0];
    end
    final_value = (cfg.relu_enable && sat_value[DW-1]) ? '0 : sat_value;
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT_SUM) begin
      sum <= (acc_rd_v ? {acc_rd[AW-1], acc_rd} : SW'(0)) +
             (cfg.bias_enable ? {{(SW - BW){bias_rd[BW-1]}}, bias_rd} : SW'(0));
    end
    if (pop && (head.cmd.mode == dlm_pkg::MODE_ACT)) begin
      act_col  <= head.cmd.column;
      act_x    <= head.cmd.sample;
      act_last <= head.cmd.last_element;
    end
    if (emit) begin
      o_index <= j;
      o_value <= final_value;
      o_last  <= (j == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      j       <= '0;
      o_valid <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && (head.cmd.mode == dlm_pkg::MODE_ACT)) begin
            j     <= '0;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          j <= j + 1'b1;
          if (j == last_idx) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Wait for the last write-back before anything reads the accumulators again.
          if (!s1_v && !s2_v) begin
            j     <= '0;
            state <= act_last ? ST_OUT_RD : ST_IDLE;
          end
        end
        ST_OUT_RD: begin
          state <= ST_OUT_SUM;
        end
        ST_OUT_SUM: begin
          state <= ST_OUT_EMIT;
        end
        ST_OUT_EMIT: begin
          if (emit) begin
            if (j == last_idx) begin
              state <= ST_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid     = o_valid;
  assign result.out_index = o_index;
  assign result.out_value = o_value;
  assign result.out_last  = o_last;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE))
    else $error("queue popped outside idle");

  a_writeback_in_mac: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> ((state == ST_MAC) || (state == ST_DRAIN)))
    else $error("accumulator write-back outside accumulation");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (emit && (j == last_idx)) |=> (o_valid && o_last && (o_index == last_idx)))
    else $error("final result carries wrong index or flag");

  a_clear_after_vector: assert property (@(posedge clk) disable iff (rst)
    clear_acc |=> ((acc_valid == '0) && (state == ST_IDLE)))
    else $error("accumulators not cleared after the vector");

endmodule

### design/dense_layer_mac_core.sv
`timescale 1ns / 1ps
// Dense layer MAC core with bias, rescaling, saturation and optional ReLU.
// Depends on dlm_pkg, the three channel interfaces, dlm_front and dlm_back.
//
// Usage: the item channel carries weight loads, bias loads and activation
// elements. Words enter a four-entry queue; the back end drains it in order.
// A load retires once it reaches the queue head and the back end is idle.
// An activation element holds the back end while it is taken from the queue,
// while one shared 16x16 multiplier serves each of the n active outputs
// (1..64) in turn, and while the read/multiply/write-back pipeline drains.
// The element marked last is followed by n results on the result channel in
// index order, each passing through accumulator and bias read, sum, and shift
// and saturate; the final one has out_last set, and the accumulators clear at
// once after it.
// The cfg channel is always ready; write it only while the block is idle.
// Reset restores the register defaults (one output, bias on, ReLU off,
// shift 8) and clears the accumulators through their valid bits; the weight
// and bias stores hold nothing defined until they are loaded.
// When the receiver stalls, the result word holds in its register, the back
// end waits, and once the queue fills the item channel drops ready.
module dense_layer_mac_core (
  input  logic      clk,
  input  logic      rst,
  dlm_in_if.sink    item,
  dlm_cfg_if.sink   cfg,
  dlm_out_if.source result
);

  dlm_pkg::cfg_t        cfg_regs;
  dlm_pkg::queue_head_t head;
  logic                 pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.out_count   <= dlm_pkg::RST_OUT_COUNT;
      cfg_regs.bias_enable <= dlm_pkg::RST_BIAS_ENABLE;
      cfg_regs.relu_enable <= dlm_pkg::RST_RELU_ENABLE;
      cfg_regs.out_shift   <= dlm_pkg::RST_OUT_SHIFT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        dlm_pkg::CFG_OUT_COUNT:   cfg_regs.out_count   <= cfg.data[dlm_pkg::CNT_W-1:0];
        dlm_pkg::CFG_BIAS_ENABLE: cfg_regs.bias_enable <= cfg.data[0];
        dlm_pkg::CFG_RELU_ENABLE: cfg_regs.relu_enable <= cfg.data[0];
        dlm_pkg::CFG_OUT_SHIFT:   cfg_regs.out_shift   <= cfg.data[dlm_pkg::SHIFT_W-1:0];
        default: begin
          cfg_regs <= cfg_regs;
        end
      endcase
    end
  end

  dlm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .head (head),
    .pop  (pop)
  );

  dlm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .cfg    (cfg_regs),
    .result (result)
  );

endmodule

### test/tb_dense_layer_mac_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for dense_layer_mac_core: weight and bias loads, streamed
// activation vectors and register phases, checked against an in-bench layer model.
// Depends on dlm_pkg and the dlm_in_if, dlm_cfg_if and dlm_out_if interfaces.
module tb_dense_layer_mac_core;

  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_WORDS = 55;
  localparam int HOLD_CYCLES  = 400;
  localparam int DW           = dlm_pkg::DATA_WIDTH;
  localparam int RW           = dlm_pkg::ROW_W;
  localparam longint SAT_HI   = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint SAT_LO   = -SAT_HI - 1;

  typedef struct {
    logic [RW-1:0] index;
    logic [DW-1:0] value;
    logic          last;
  } neuron_out_t;

  logic clk = 1'b0;
  logic rst;

  dlm_in_if  in_ch();
  dlm_cfg_if cfg_ch();
  dlm_out_if out_ch();

  dense_layer_mac_core dut (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .cfg(cfg_ch),
    .result(out_ch)
  );

  // Layer model state, kept in step with every accepted word.
  logic signed [DW-1:0]             wt_mem [dlm_pkg::MAX_OUTPUTS][dlm_pkg::MAX_INPUTS];
  bit                               wt_set [dlm_pkg::MAX_OUTPUTS][dlm_pkg::MAX_INPUTS];
  logic signed [dlm_pkg::BIAS_W-1:0] bias_mem [dlm_pkg::MAX_OUTPUTS];
  bit                               bias_set [dlm_pkg::MAX_OUTPUTS];
  logic [dlm_pkg::ACC_W-1:0]        acc [dlm_pkg::MAX_OUTPUTS];
  dlm_pkg::cfg_t                    regs;

  neuron_out_t pending_outputs[$];
  neuron_out_t want_out;

  int mismatches = 0;
  int outputs_checked = 0;
  int words_sent = 0;
  int vectors_done = 0;
  int wide_col = 0;
  int stall_left = 0;
  logic rx_hold = 1'b0;
  event hold_go;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int active_outputs();
    if (regs.out_count == 0) return 1;
    if (regs.out_count > dlm_pkg::MAX_OUTPUTS) return dlm_pkg::MAX_OUTPUTS;
    return int'(regs.out_count);
  endfunction

  function automatic dlm_pkg::cmd_t make_word(input logic [dlm_pkg::MODE_W-1:0] mode,
                                              input int row, input int column,
                                              input logic [DW-1:0] sample,
                                              input logic [dlm_pkg::BIAS_W-1:0] bias,
                                              input bit last);
    dlm_pkg::cmd_t w;
    w.mode         = mode;
    w.row          = row[RW-1:0];
    w.column       = column[dlm_pkg::COL_W-1:0];
    w.sample       = sample;
    w.bias_word    = bias;
    w.last_element = last;
    return w;
  endfunction

  function automatic bit random_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Applies one accepted word to the layer model and queues the neuron outputs
  // that a closing activation produces.
  function automatic void layer_update(input dlm_pkg::cmd_t w);
    int n;
    logic signed [dlm_pkg::PROD_W-1:0] prod;
    logic signed [63:0] total;
    neuron_out_t r;
    n = active_outputs();
    case (w.mode)
      dlm_pkg::MODE_WEIGHT: begin
        wt_mem[w.row][w.column] = w.sample;
        wt_set[w.row][w.column] = 1'b1;
      end
      dlm_pkg::MODE_BIAS: begin
        bias_mem[w.row] = w.bias_word;
        bias_set[w.row] = 1'b1;
      end
      dlm_pkg::MODE_ACT: begin
        for (int j = 0; j < n; j++) begin
          prod = $signed(w.sample) * wt_mem[j][w.column];
          acc[j] = acc[j] + {{(dlm_pkg::ACC_W - dlm_pkg::PROD_W){prod[dlm_pkg::PROD_W-1]}},
                             prod};
        end
        if (w.last_element) begin
          for (int j = 0; j < n; j++) begin
            total = {{(64 - dlm_pkg::ACC_W){acc[j][dlm_pkg::ACC_W-1]}}, acc[j]};
            if (regs.bias_enable) total = total + 64'(bias_mem[j]);
            total = total >>> regs.out_shift;
            if (total > SAT_HI) total = SAT_HI;
            if (total < SAT_LO) total = SAT_LO;
            if (regs.relu_enable && total < 0) total = 0;
            r.index = j[RW-1:0];
            r.value = total[DW-1:0];
            r.last  = (j == n - 1);
            pending_outputs.push_back(r);
          end
          foreach (acc[j]) acc[j] = '0;
          vectors_done++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input dlm_pkg::cmd_t w);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= w.mode;
    in_ch.row          <= w.row;
    in_ch.column       <= w.column;
    in_ch.sample       <= w.sample;
    in_ch.bias_word    <= w.bias_word;
    in_ch.last_element <= w.last_element;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    layer_update(w);
    if (w.mode != dlm_pkg::MODE_NONE) words_sent++;
  endtask

  // Stops offering words and waits until every queued output has arrived and the
  // core has had time to retire loads that produce no output.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dlm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlm_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      dlm_pkg::CFG_OUT_COUNT:   regs.out_count   = value[dlm_pkg::CNT_W-1:0];
      dlm_pkg::CFG_BIAS_ENABLE: regs.bias_enable = value[0];
      dlm_pkg::CFG_RELU_ENABLE: regs.relu_enable = value[0];
      dlm_pkg::CFG_OUT_SHIFT:   regs.out_shift   = value[dlm_pkg::SHIFT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Unused upper data bits carry random junk that the core must ignore.
  task automatic configure(input int count, input bit bias_on, input bit relu_on,
                           input int shift);
    wait_idle();
    write_reg(dlm_pkg::CFG_OUT_COUNT,
              ($urandom & ~32'h7F) | 32'(count[dlm_pkg::CNT_W-1:0]));
    write_reg(dlm_pkg::CFG_BIAS_ENABLE, ($urandom & ~32'h1) | 32'(bias_on));
    write_reg(dlm_pkg::CFG_RELU_ENABLE, ($urandom & ~32'h1) | 32'(relu_on));
    write_reg(dlm_pkg::CFG_OUT_SHIFT,
              ($urandom & ~32'h1F) | 32'(shift[dlm_pkg::SHIFT_W-1:0]));
  endtask

  function automatic logic [DW-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic int pick_shift();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 31;
      2: return $urandom_range(0, 31);
      default: return $urandom_range(4, 16);
    endcase
  endfunction

  // Loads every weight and bias that an activation in this column will read.
  task automatic prepare_column(input int n, input int col);
    for (int j = 0; j < n; j++) begin
      if (!wt_set[j][col])
        send_word(make_word(dlm_pkg::MODE_WEIGHT, j, col, random_sample(), $urandom,
                            random_bit()));
      if (!bias_set[j])
        send_word(make_word(dlm_pkg::MODE_BIAS, j, $urandom, DW'($urandom), $urandom,
                            random_bit()));
    end
  endtask

  function automatic dlm_pkg::cmd_t noise_word();
    case ($urandom_range(0, 2))
      0: return make_word(dlm_pkg::MODE_NONE, $urandom, $urandom, DW'($urandom), $urandom,
                          random_bit());
      1: return make_word(dlm_pkg::MODE_WEIGHT, $urandom, $urandom, DW'($urandom),
                          $urandom, random_bit());
      default: return make_word(dlm_pkg::MODE_BIAS, $urandom, $urandom, DW'($urandom),
                                $urandom, random_bit());
    endcase
  endfunction

  task automatic test_directed_basics();
    // Reset registers: one output, bias on, ReLU off, shift 8.
    send_word(make_word(dlm_pkg::MODE_WEIGHT, 0, 0, 16'h7FFF, 32'h0, 1'b1));
    send_word(make_word(dlm_pkg::MODE_WEIGHT, 0, 1023, 16'h8000, 32'hFFFF_FFFF, 1'b0));
    send_word(make_word(dlm_pkg::MODE_BIAS, 0, 1023, 16'hFFFF, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(dlm_pkg::MODE_BIAS, 63, 0, 16'h0, 32'h8000_0000, 1'b0));
    send_word(make_word(dlm_pkg::MODE_WEIGHT, 63, 1023, 16'hFFFF, 32'h0, 1'b0));
    send_word(make_word(dlm_pkg::MODE_NONE, 63, 1023, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 0, 16'h8000, 32'h0, 1'b0));
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 1023, 16'h8000, 32'h0, 1'b1));
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 0, 16'h7FFF, 32'h0, 1'b1));
    send_word(make_word(dlm_pkg::MODE_ACT, 63, 1023, 16'h0000, 32'hFFFF_FFFF, 1'b1));
    // ReLU clamps a negative sum; a positive one passes.
    configure(1, 1'b0, 1'b1, 8);
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 1023, 16'h7FFF, 32'h0, 1'b1));
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 0, 16'h7FFF, 32'h0, 1'b1));
    // No shift: negative saturation and the largest value that fits.
    configure(1, 1'b0, 1'b0, 0);
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 0, 16'h8000, 32'h0, 1'b1));
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 0, 16'h0001, 32'h0, 1'b1));
    // The widest shift rounds toward minus infinity.
    configure(1, 1'b0, 1'b0, 31);
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 1023, 16'h0001, 32'h0, 1'b1));
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 0, 16'h0001, 32'h0, 1'b1));
    configure(1, 1'b1, 1'b0, 31);
    send_word(make_word(dlm_pkg::MODE_ACT, 0, 0, 16'h0001, 32'h0, 1'b1));
  endtask

  task automatic test_output_count_limits();
    // A count of zero behaves as one output.
    configure(0, 1'b1, 1'b0, 8);
    send_word(make_word(dlm_pkg::MODE_ACT, $urandom, 0, random_sample(), $urandom, 1'b1));
    wide_col = $urandom_range(1, dlm_pkg::MAX_INPUTS - 2);
    prepare_column(dlm_pkg::MAX_OUTPUTS, wide_col);
    // Counts above the output limit behave as the full width.
    configure(127, 1'b1, 1'b1, 10);
    send_word(make_word(dlm_pkg::MODE_ACT, $urandom, wide_col, random_sample(), $urandom,
                        1'b0));
    send_word(make_word(dlm_pkg::MODE_ACT, $urandom, wide_col, random_sample(), $urandom,
                        1'b1));
    configure(dlm_pkg::MAX_OUTPUTS, 1'b1, 1'b0, 12);
    send_word(make_word(dlm_pkg::MODE_ACT, $urandom, wide_col, random_sample(), $urandom,
                        1'b1));
  endtask

  task automatic test_random_layers();
    int n;
    int col;
    int len;
    int first;
    int cols[$];
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      configure(n, random_bit(), random_bit(), pick_shift());
      cols.delete();
      repeat ($urandom_range(1, 4)) begin
        col = $urandom_range(0, dlm_pkg::MAX_INPUTS - 1);
        cols.push_back(col);
        prepare_column(n, col);
      end
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 5);
        for (int e = 0; e < len; e++) begin
          if ($urandom_range(0, 9) == 0) send_word(noise_word());
          // Now and then a vector is left open and runs on into the next one.
          send_word(make_word(dlm_pkg::MODE_ACT, $urandom,
                              cols[$urandom_range(0, cols.size() - 1)],
                              random_sample(), $urandom,
                              (e == len - 1) && ($urandom_range(0, 7) != 0)));
        end
      end
    end
  endtask

  task automatic test_result_backpressure();
    configure(dlm_pkg::MAX_OUTPUTS, 1'b1, 1'b0, 9);
    // The receiver holds off long enough for the input queue to fill and stall.
    -> hold_go;
    repeat (6)
      send_word(make_word(dlm_pkg::MODE_ACT, $urandom, wide_col, random_sample(), $urandom,
                          1'b1));
  endtask

  // Result receiver: random stalls after each word, plus the long hold below.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) stall_left = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !rx_hold;
      end
    end
  end

  initial begin : receiver_hold
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output index %0d value %0d last %0b", $realtime,
                   out_ch.out_index, $signed(out_ch.out_value), out_ch.out_last);
      end else begin
        want_out = pending_outputs.pop_front();
        outputs_checked++;
        if (out_ch.out_index !== want_out.index || out_ch.out_value !== want_out.value ||
            out_ch.out_last !== want_out.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: output mismatch: expected index %0d value %0d last %0b,",
                      " got index %0d value %0d last %0b"},
                     $realtime, want_out.index, $signed(want_out.value), want_out.last,
                     out_ch.out_index, $signed(out_ch.out_value), out_ch.out_last);
        end
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= dlm_pkg::MODE_NONE;
    in_ch.row          <= '0;
    in_ch.column       <= '0;
    in_ch.sample       <= '0;
    in_ch.bias_word    <= '0;
    in_ch.last_element <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= dlm_pkg::CFG_OUT_COUNT;
    cfg_ch.data        <= '0;
    regs.out_count   = dlm_pkg::RST_OUT_COUNT;
    regs.bias_enable = dlm_pkg::RST_BIAS_ENABLE;
    regs.relu_enable = dlm_pkg::RST_RELU_ENABLE;
    regs.out_shift   = dlm_pkg::RST_OUT_SHIFT;
    foreach (acc[j]) acc[j] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_basics();
    test_output_count_limits();
    test_random_layers();
    test_result_backpressure();
    wait_idle();
    $display("Run covered %0d words, %0d closed vectors and %0d checked outputs:", words_sent,
             vectors_done, outputs_checked);
    $display("directed extremes, count limits, random layers and a long result stall.");
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("tb_dense_layer_mac_core passed");
    end else begin
      $display("tb_dense_layer_mac_core failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Timeout with %0d outputs still expected.", pending_outputs.size());
    $display("tb_dense_layer_mac_core failed");
    $finish;
  end

endmodule
